// File: rtl/core/led_matrix_595_scanner_assert.svh
// ----------------------------------------------------------------------------
// LED matrix scanner assertion macros
// Shorthand for the implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_595_SCANNER_ASSERT_SVH
`define LED_MATRIX_595_SCANNER_ASSERT_SVH

// same-cycle implication
`define LMS_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("lms: check failed");

// next-cycle implication
`define LMS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("lms: check failed");

`endif

// File: rtl/core/lms_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix scanner package
// Shared types and constants for the 74HC595 matrix scanner.
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam int STORE_DEPTH = 128;
  localparam int ADDR_W      = 7;
  localparam int BYTE_W      = 8;
  localparam int DWELL_W     = 16;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS = 4'd1;

  localparam logic [MODE_W-1:0]  MODE_RED   = 2'd0;
  localparam logic [MODE_W-1:0]  MODE_GREEN = 2'd1;
  localparam logic [MODE_W-1:0]  COLOR_MODE_RESET  = MODE_RED;
  localparam logic [DWELL_W-1:0] DWELL_TICKS_RESET = 16'd100;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [3:0] {
    PH_BLANK,
    PH_BLANK_LATCH,
    PH_RED_SHIFT,
    PH_GREEN_SHIFT,
    PH_RED_LATCH,
    PH_GREEN_LATCH,
    PH_ROW_SHIFT,
    PH_ROW_LATCH,
    PH_DWELL
  } phase_t;

  typedef struct packed {
    logic green_latch;
    logic green_data;
    logic green_clock;
    logic red_latch;
    logic red_data;
    logic red_clock;
    logic row_latch;
    logic row_data;
    logic row_clock;
  } pins_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } wr_req_t;

  function automatic phase_t next_phase(input phase_t ph);
    phase_t n;
    case (ph)
      PH_BLANK:       n = PH_BLANK_LATCH;
      PH_BLANK_LATCH: n = PH_RED_SHIFT;
      PH_RED_SHIFT:   n = PH_GREEN_SHIFT;
      PH_GREEN_SHIFT: n = PH_RED_LATCH;
      PH_RED_LATCH:   n = PH_GREEN_LATCH;
      PH_GREEN_LATCH: n = PH_ROW_SHIFT;
      PH_ROW_SHIFT:   n = PH_ROW_LATCH;
      PH_ROW_LATCH:   n = PH_DWELL;
      default:        n = PH_BLANK;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/core/lms_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/lms_store.sv
// ----------------------------------------------------------------------------
// LED matrix frame store
// 128-byte frame RAM with per-entry valid bits; unwritten bytes read as zero.
// ----------------------------------------------------------------------------
module lms_store (
  input  logic                        clk,
  input  logic                        rst,
  input  lms_pkg::wr_req_t            wr,
  input  lms_pkg::rd_req_t            rd,
  output logic [lms_pkg::BYTE_W-1:0]  rd_data
);
  import lms_pkg::*;

  logic [STORE_DEPTH-1:0] valid;
  logic                   rd_valid;
  logic [BYTE_W-1:0]      ram_data;

  lms_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd.en),
    .rd_addr (rd.addr),
    .rd_data (ram_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_valid <= valid[rd.addr];
      end
    end
  end

  assign rd_data = rd_valid ? ram_data : '0;

endmodule

// File: rtl/core/lms_scan.sv
// ----------------------------------------------------------------------------
// LED matrix scan sequencer
// Steps the per-row pin sequence one tick at a time and fetches column bytes.
// ----------------------------------------------------------------------------
module lms_scan #(
  parameter int ROW_COUNT = 16,
  parameter int ROW_BYTES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         tick,
  input  logic [lms_pkg::MODE_W-1:0]   color_mode,
  input  logic [lms_pkg::DWELL_W-1:0]  dwell_ticks,
  input  logic [lms_pkg::BYTE_W-1:0]   rd_data,
  output lms_pkg::rd_req_t             rd,
  output lms_pkg::pins_t               snap
);
  import lms_pkg::*;

  localparam int H       = ROW_COUNT / 2;
  localparam int JW      = $clog2(H + 1);
  localparam int SW      = 2;
  localparam int BIT_W   = ($clog2(ROW_COUNT + 1) > 4) ? $clog2(ROW_COUNT + 1) : 4;
  localparam int BCNT_W  = $clog2(ROW_BYTES + 1);
  localparam int POS_W   = 8;
  localparam int S_LAST  = (ROW_COUNT - 1) / H;
  localparam int J_LAST  = (ROW_COUNT - 1) % H;
  localparam logic [ADDR_W-1:0] GROUP_BASE = ADDR_W'(ROW_BYTES - 2);
  localparam logic [ADDR_W-1:0] ROW_MULT   = ADDR_W'(ROW_COUNT);

  phase_t              phase, phase_next, ph_e;
  logic [SW-1:0]       row_s, row_s_next, row_s_inc;
  logic [JW-1:0]       row_j, row_j_next, row_j_inc;
  logic [BIT_W-1:0]    bit_count, bit_count_next, bit_e, bit_n;
  logic [BCNT_W-1:0]   byte_index, byte_index_next, byte_e, byte_n;
  logic                half_step, half_step_next, half_e;
  logic [DWELL_W-1:0]  dwell_count, dwell_count_next, dwell_e;
  logic [BYTE_W-1:0]   shift_byte, shift_byte_next, shift_src;
  pins_t               pins, pins_next, pins_act;
  logic                rd_pend;
  logic                red_on, green_on;
  logic                row_skip, advance;
  logic [ADDR_W-1:0]   group, col_addr;
  logic [POS_W-1:0]    row_pos;

  assign red_on    = (color_mode != MODE_GREEN);
  assign green_on  = (color_mode != MODE_RED);
  assign shift_src = rd_pend ? rd_data : shift_byte;

  always_comb begin
    if (row_s == SW'(S_LAST) && row_j == JW'(J_LAST)) begin
      row_s_inc = '0;
      row_j_inc = '0;
    end else if (row_j == JW'(H - 1)) begin
      row_s_inc = row_s + SW'(1);
      row_j_inc = '0;
    end else begin
      row_s_inc = row_s;
      row_j_inc = row_j + JW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BLANK;
    end else if (tick) begin
      phase <= phase_next;
    end
  end

  always_comb begin
    ph_e     = phase;
    bit_e    = bit_count;
    byte_e   = byte_index;
    half_e   = half_step;
    dwell_e  = dwell_count;
    row_skip = 1'b0;
    case (phase)
      PH_RED_SHIFT:   if (!red_on)   ph_e = PH_GREEN_SHIFT;
      PH_GREEN_SHIFT: if (!green_on) ph_e = PH_RED_LATCH;
      PH_RED_LATCH:   if (!red_on)   ph_e = PH_GREEN_LATCH;
      PH_GREEN_LATCH: if (!green_on) ph_e = PH_ROW_SHIFT;
      PH_DWELL: begin
        if (dwell_count >= dwell_ticks) begin
          ph_e     = PH_BLANK;
          row_skip = 1'b1;
        end
      end
      default: ;
    endcase
    if (ph_e != phase) begin
      bit_e   = '0;
      byte_e  = '0;
      half_e  = 1'b0;
      dwell_e = '0;
    end

    group    = GROUP_BASE - ADDR_W'({byte_e >> 1, 1'b0}) + ADDR_W'(row_s);
    col_addr = ADDR_W'(group * ROW_MULT) + ADDR_W'({row_j, 1'b0}) + ADDR_W'(1)
             - ADDR_W'(byte_e[0]);
    row_pos  = POS_W'(row_s) * POS_W'(H) + POS_W'(H - 1) - POS_W'(row_j);

    bit_n            = bit_e + BIT_W'(1);
    byte_n           = byte_e + BCNT_W'(1);
    phase_next       = ph_e;
    bit_count_next   = bit_e;
    byte_index_next  = byte_e;
    half_step_next   = half_e;
    dwell_count_next = dwell_e;
    shift_byte_next  = shift_src;
    pins_act         = pins;
    pins_next        = pins;
    rd.en            = 1'b0;
    rd.addr          = col_addr;
    advance          = 1'b0;

    case (ph_e)
      PH_BLANK, PH_ROW_SHIFT: begin
        if (!half_e) begin
          pins_act.row_clock = 1'b1;
          half_step_next     = 1'b1;
        end else begin
          pins_act.row_data  = (ph_e == PH_ROW_SHIFT) && (POS_W'(bit_e) == row_pos);
          pins_act.row_clock = 1'b0;
          half_step_next     = 1'b0;
          bit_count_next     = bit_n;
          advance            = (bit_n >= BIT_W'(ROW_COUNT));
        end
        pins_next = pins_act;
      end
      PH_RED_SHIFT, PH_GREEN_SHIFT: begin
        if (!half_e) begin
          rd.en = tick && (bit_e == '0);
          if (ph_e == PH_RED_SHIFT) begin
            pins_act.red_clock = 1'b1;
          end else begin
            pins_act.green_clock = 1'b1;
          end
          half_step_next = 1'b1;
        end else begin
          if (ph_e == PH_RED_SHIFT) begin
            pins_act.red_data  = ~shift_src[0];
            pins_act.red_clock = 1'b0;
          end else begin
            pins_act.green_data  = ~shift_src[0];
            pins_act.green_clock = 1'b0;
          end
          shift_byte_next = shift_src >> 1;
          half_step_next  = 1'b0;
          if (bit_n >= BIT_W'(8)) begin
            bit_count_next  = '0;
            byte_index_next = byte_n;
            advance         = (byte_n >= BCNT_W'(ROW_BYTES));
          end else begin
            bit_count_next = bit_n;
          end
        end
        pins_next = pins_act;
      end
      PH_BLANK_LATCH, PH_RED_LATCH, PH_GREEN_LATCH, PH_ROW_LATCH: begin
        if (!half_e) begin
          case (ph_e)
            PH_RED_LATCH:   pins_act.red_latch   = 1'b1;
            PH_GREEN_LATCH: pins_act.green_latch = 1'b1;
            default:        pins_act.row_latch   = 1'b1;
          endcase
          half_step_next = 1'b1;
          pins_next      = pins_act;
        end else begin
          case (ph_e)
            PH_RED_LATCH:   pins_act.red_latch   = 1'b0;
            PH_GREEN_LATCH: pins_act.green_latch = 1'b0;
            default:        pins_act.row_latch   = 1'b0;
          endcase
          half_step_next = 1'b0;
          advance        = 1'b1;
          // latch line returns high after the snapshot
          pins_next      = pins_act;
          case (ph_e)
            PH_RED_LATCH:   pins_next.red_latch   = 1'b1;
            PH_GREEN_LATCH: pins_next.green_latch = 1'b1;
            default:        pins_next.row_latch   = 1'b1;
          endcase
        end
      end
      default: begin
        dwell_count_next = dwell_e + DWELL_W'(1);
        advance = ({1'b0, dwell_e} + (DWELL_W + 1)'(1)) >= {1'b0, dwell_ticks};
      end
    endcase

    row_s_next = (row_skip || (advance && ph_e == PH_DWELL)) ? row_s_inc : row_s;
    row_j_next = (row_skip || (advance && ph_e == PH_DWELL)) ? row_j_inc : row_j;
    if (advance) begin
      phase_next       = next_phase(ph_e);
      bit_count_next   = '0;
      byte_index_next  = '0;
      half_step_next   = 1'b0;
      dwell_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_s       <= '0;
      row_j       <= '0;
      bit_count   <= '0;
      byte_index  <= '0;
      half_step   <= 1'b0;
      dwell_count <= '0;
      shift_byte  <= '0;
      pins        <= '0;
      rd_pend     <= 1'b0;
    end else begin
      rd_pend <= rd.en;
      if (tick) begin
        row_s       <= row_s_next;
        row_j       <= row_j_next;
        bit_count   <= bit_count_next;
        byte_index  <= byte_index_next;
        half_step   <= half_step_next;
        dwell_count <= dwell_count_next;
        shift_byte  <= shift_byte_next;
        pins        <= pins_next;
      end else begin
        shift_byte <= shift_src;
      end
    end
  end

  assign snap = tick ? pins_act : pins;

endmodule

// File: rtl/core/led_matrix_595_scanner.sv
// ----------------------------------------------------------------------------
// LED matrix 74HC595 scanner
// Frame store plus tick-driven pin sequencer for a two-color LED matrix.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       op, address, data
//   m_axis    out  m_axis_tvalid/tready       pin snapshot and enables
//   cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One item per cycle unless m_axis stalls: a tick or a frame write is settled
// when accepted and its result sits in the output register on the next cycle.
// A column byte read from the frame RAM is registered and returns in the next
// cycle; it is forwarded to the shift logic for the following tick.
// Reset clears the frame store's valid bits directly; no clearing pass.
// A new item is taken while a result waits, as long as m_axis_tready is high.
// ----------------------------------------------------------------------------
module led_matrix_595_scanner #(
  parameter int ROW_COUNT = 16,
  parameter int ROW_BYTES = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // address[6:0], data[14:7], zero [15]
  input  logic [lms_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // op[0]
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // row_clock, row_data, row_latch, red_clock, red_data, red_latch,
  // green_clock, green_data, green_latch, row_enable, red_enable,
  // green_enable [11:0], zero [15:12]
  output logic [lms_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lms_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lms_pkg::*;

  logic                accept, tick;
  logic [MODE_W-1:0]   color_mode;
  logic [DWELL_W-1:0]  dwell_ticks;
  wr_req_t             wr;
  rd_req_t             rd;
  logic [BYTE_W-1:0]   rd_data;
  pins_t               snap;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready     = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign tick          = accept && (s_axis_tuser[0] == OP_TICK);

  assign wr.en   = accept && (s_axis_tuser[0] == OP_WRITE);
  assign wr.addr = s_axis_tdata[ADDR_W-1:0];
  assign wr.data = s_axis_tdata[ADDR_W +: BYTE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode  <= COLOR_MODE_RESET;
      dwell_ticks <= DWELL_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COLOR_MODE:  color_mode  <= cfg_data[MODE_W-1:0];
        CFG_DWELL_TICKS: dwell_ticks <= cfg_data[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  lms_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  lms_scan #(
    .ROW_COUNT (ROW_COUNT),
    .ROW_BYTES (ROW_BYTES)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .color_mode  (color_mode),
    .dwell_ticks (dwell_ticks),
    .rd_data     (rd_data),
    .rd          (rd),
    .snap        (snap)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {4'b0000, color_mode != MODE_RED, color_mode != MODE_GREEN,
                       1'b1, snap};
    end
  end

endmodule

// File: rtl/core/lms_checker.sv
// ----------------------------------------------------------------------------
// LED matrix scanner port checker
// Port-level checks on the input and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "led_matrix_595_scanner_assert.svh"

module lms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  `LMS_ASSERT_NEXT(a_item_gives_result, clk, rst, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
  `LMS_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_axis_tvalid, s_axis_tready)
  `LMS_ASSERT_NOW(a_row_enable_on, clk, rst, m_axis_tvalid, m_axis_tdata[9])
  `LMS_ASSERT_NOW(a_one_chain_on, clk, rst, m_axis_tvalid, m_axis_tdata[10] || m_axis_tdata[11])
  `LMS_ASSERT_NEXT(a_result_held, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind led_matrix_595_scanner lms_checker u_lms_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
